/* rtl/htr_pkg.sv */
package htr_pkg;

   localparam int POS_BITS      = 6;
   localparam int GW_BITS       = 7;
   localparam int THR_BITS      = 15;
   localparam int RANK_BITS     = 12;
   localparam int DEF_MAX_WIDTH = 64;
   localparam int GW_MAX        = (1 << GW_BITS) - 1;

   localparam int CSR_IDX_BITS  = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PRECISION_MODE = 2'd1;

   localparam logic [GW_BITS-1:0] GRID_WIDTH_RESET = 7'd64;
   localparam logic [GW_BITS-1:0] GRID_WIDTH_MIN   = 7'd2;

   localparam logic PREC_8BIT  = 1'b0;
   localparam logic PREC_15BIT = 1'b1;

endpackage

/* rtl/halftone_threshold_rank_top.sv */
// Channel  Direction  Handshake             Beat payload
// req      in         req_valid/req_stall   req_column, req_line_index
// rsp      out        rsp_valid/rsp_stall   rsp_threshold, rsp_cell_rank
// csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// With w the effective grid width, the single spot-value unit visits every
// cell of the w*w screen once, one cell per cycle, and a 15-step restoring
// divider then scales the rank.
// The block takes one request at a time and holds req_stall high while busy.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous and active high; csr_ready is always high.
module halftone_threshold_rank_top
   import htr_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [POS_BITS-1:0]     req_column,
   input  logic [POS_BITS-1:0]     req_line_index,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [THR_BITS-1:0]     rsp_threshold,
   output logic [RANK_BITS-1:0]    rsp_cell_rank,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [GW_BITS-1:0]      csr_wdata
);

   localparam int EFF_MAX = (MAX_WIDTH < GW_MAX) ? MAX_WIDTH : GW_MAX;
   localparam int CBITS   = $clog2(EFF_MAX);
   localparam int PW      = (CBITS > POS_BITS) ? CBITS : POS_BITS;
   localparam int WWBITS  = $clog2(EFF_MAX * EFF_MAX + 1);
   localparam int SW      = 2 * CBITS + 3;
   localparam int NBITS   = WWBITS + THR_BITS;
   localparam int RKX     = (WWBITS > RANK_BITS) ? WWBITS : RANK_BITS;
   localparam int DCBITS  = $clog2(THR_BITS);
   localparam logic [GW_BITS-1:0] EFF_MAX_GW = GW_BITS'(EFF_MAX);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_KEY   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_PREP  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [GW_BITS-1:0]      grid_width_ff;
   logic                    precision_mode_ff;

   logic                    mode_ff;
   logic [CBITS-1:0]        d_ff;
   logic [CBITS-1:0]        cx_ff, cy_ff;
   logic [CBITS-1:0]        x_ff, y_ff;
   logic [SW-1:0]           dd_ff;
   logic [WWBITS-1:0]       ww_ff;
   logic signed [SW-1:0]    key_ff, v_ff;
   logic                    pv_ff, pre_ff;
   logic [WWBITS-1:0]       rank_ff;
   logic [WWBITS-1:0]       rem_ff;
   logic [THR_BITS-1:0]     q_ff;
   logic [DCBITS-1:0]       dcnt_ff;
   logic                    rsp_valid_ff;
   logic [THR_BITS-1:0]     rsp_threshold_ff;
   logic [RANK_BITS-1:0]    rsp_cell_rank_ff;

   logic                    accept;
   logic                    rsp_free;
   logic [GW_BITS-1:0]      w_eff;
   logic [CBITS-1:0]        d_eff;
   logic [PW-1:0]           col_x, line_x, d_x;

   logic [CBITS-1:0]        ux, uy;
   logic signed [CBITS+1:0] ta, tb;
   logic [CBITS+1:0]        aa_full, ab_full;
   logic [CBITS-1:0]        aa, ab, sa, sb;
   logic [CBITS:0]          absum;
   logic                    outside;
   logic [SW-1:0]           sqsum;
   logic signed [SW-1:0]    v_raw, v_lim, v;

   logic                    scan_end;
   logic                    cell_before;
   logic                    hit;
   logic [NBITS-1:0]        num;
   logic [WWBITS:0]         r2;
   logic                    ge;
   logic [RKX-1:0]          rank_x;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_threshold = rsp_threshold_ff;
   assign rsp_cell_rank = rsp_cell_rank_ff;

   always_comb begin
      if (grid_width_ff < GRID_WIDTH_MIN) begin
         w_eff = GRID_WIDTH_MIN;
      end else if (grid_width_ff > EFF_MAX_GW) begin
         w_eff = EFF_MAX_GW;
      end else begin
         w_eff = grid_width_ff;
      end
      d_eff  = CBITS'(w_eff - 7'd1);
      col_x  = PW'(req_column);
      line_x = PW'(req_line_index);
      d_x    = PW'(d_eff);
   end

   // Spot-value unit, shared by the key cell and every scanned cell.
   always_comb begin
      ux      = (state_ff == S_KEY) ? cx_ff : x_ff;
      uy      = (state_ff == S_KEY) ? cy_ff : y_ff;
      ta      = $signed({1'b0, ux, 1'b0}) - $signed({2'b00, d_ff});
      tb      = $signed({1'b0, uy, 1'b0}) - $signed({2'b00, d_ff});
      aa_full = ta[CBITS+1] ? $unsigned(-ta) : $unsigned(ta);
      ab_full = tb[CBITS+1] ? $unsigned(-tb) : $unsigned(tb);
      aa      = aa_full[CBITS-1:0];
      ab      = ab_full[CBITS-1:0];
      absum   = {1'b0, aa} + {1'b0, ab};
      outside = absum > {1'b0, d_ff};
      sa      = outside ? (d_ff - aa) : aa;
      sb      = outside ? (d_ff - ab) : ab;
      sqsum   = SW'(sa * sa) + SW'(sb * sb);
      v_raw   = outside ? $signed(sqsum - dd_ff) : $signed(dd_ff - sqsum);
      if (v_raw > $signed(dd_ff)) begin
         v_lim = $signed(dd_ff);
      end else begin
         v_lim = v_raw;
      end
      if (v_lim < -$signed(dd_ff)) begin
         v = -$signed(dd_ff);
      end else begin
         v = v_lim;
      end
   end

   always_comb begin
      scan_end    = (x_ff == d_ff) && (y_ff == d_ff);
      cell_before = (y_ff < cy_ff) || ((y_ff == cy_ff) && (x_ff < cx_ff));
      hit         = pv_ff && ((v_ff < key_ff) || ((v_ff == key_ff) && pre_ff));
      if (mode_ff == PREC_15BIT) begin
         num = {rank_ff, {THR_BITS{1'b0}}};
      end else begin
         num = NBITS'({rank_ff, 8'd0}) - NBITS'(rank_ff);
      end
      r2     = {rem_ff, q_ff[THR_BITS-1]};
      ge     = r2 >= {1'b0, ww_ff};
      rank_x = RKX'(rank_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_PREP;
         end
         S_PREP: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (dcnt_ff == DCBITS'(THR_BITS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         grid_width_ff     <= GRID_WIDTH_RESET;
         precision_mode_ff <= PREC_8BIT;
         rsp_valid_ff      <= 1'b0;
         pv_ff             <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GRID_WIDTH) begin
               grid_width_ff <= csr_wdata;
            end else if (csr_index == CSR_PRECISION_MODE) begin
               precision_mode_ff <= csr_wdata[0];
            end
         end
         pv_ff <= (state_ff == S_SCAN);
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && accept) begin
         mode_ff <= precision_mode_ff;
         d_ff    <= d_eff;
         dd_ff   <= SW'(d_eff * d_eff);
         cx_ff   <= (col_x > d_x) ? d_eff : CBITS'(col_x);
         cy_ff   <= (line_x > d_x) ? d_eff : CBITS'(line_x);
      end
      if (state_ff == S_KEY) begin
         key_ff  <= v;
         ww_ff   <= WWBITS'(dd_ff + SW'({d_ff, 1'b1}));
         x_ff    <= '0;
         y_ff    <= '0;
         rank_ff <= '0;
      end
      if (state_ff == S_SCAN) begin
         v_ff   <= v;
         pre_ff <= cell_before;
         if (x_ff == d_ff) begin
            x_ff <= '0;
            y_ff <= y_ff + CBITS'(1);
         end else begin
            x_ff <= x_ff + CBITS'(1);
         end
      end
      if ((state_ff == S_SCAN || state_ff == S_DRAIN) && hit) begin
         rank_ff <= rank_ff + WWBITS'(1);
      end
      if (state_ff == S_PREP) begin
         rem_ff  <= num[NBITS-1:THR_BITS];
         q_ff    <= num[THR_BITS-1:0];
         dcnt_ff <= '0;
      end
      if (state_ff == S_DIV) begin
         rem_ff  <= ge ? WWBITS'(r2 - {1'b0, ww_ff}) : r2[WWBITS-1:0];
         q_ff    <= {q_ff[THR_BITS-2:0], ge};
         dcnt_ff <= dcnt_ff + DCBITS'(1);
      end
      if (state_ff == S_DONE && rsp_free) begin
         rsp_threshold_ff <= q_ff;
         rsp_cell_rank_ff <= rank_x[RANK_BITS-1:0];
      end
   end

endmodule

/* rtl/htr_checker.sv */
module htr_checker
   import htr_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [POS_BITS-1:0]     req_column,
   input logic [POS_BITS-1:0]     req_line_index,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [THR_BITS-1:0]     rsp_threshold,
   input logic [RANK_BITS-1:0]    rsp_cell_rank,
   input logic                    csr_valid,
   input logic                    csr_ready,
   input logic [CSR_IDX_BITS-1:0] csr_index,
   input logic [GW_BITS-1:0]      csr_wdata
);

   // A waiting result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_threshold)
         && $stable(rsp_cell_rank))
   else $error("stalled result beat changed");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
   else $error("request taken while busy");

   // A result never appears in the cycle after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
   else $error("result produced too early");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
   else $error("result valid after reset");

endmodule

bind halftone_threshold_rank_top htr_checker u_htr_checker (.*);
